FILE: design/bitmap_first_free_allocator_top_defines.svh
// Assertion macros shared by the bitmap allocator RTL.
// Expects a clock named clk and a reset named rst in the including module.
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_TOP_DEFINES_SVH

// Check at every edge, reset included.
`define BFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check outside reset only.
`define BFA_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

FILE: design/bfa_pkg.sv
// Package for the bitmap first-free allocator: beat types, action codes, row geometry.
// No dependencies.
package bfa_pkg;

  localparam int BYTE_BITS            = 8;
  localparam int LANES                = 16;
  localparam int LANE_AW              = 4;
  localparam int ROW_BITS             = LANES * BYTE_BITS;
  localparam int SEARCH_SPAN          = 1024;
  localparam int BITMAP_BYTES_DEFAULT = 1024;
  localparam logic [10:0] BYTES_IN_USE_RESET = 11'd1024;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_ALLOC = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [9:0] byte_addr;
    logic [7:0] byte_data;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [12:0] bit_index;
    logic [7:0]  read_data;
  } rsp_t;

  typedef struct packed {
    logic               hit;
    logic [LANE_AW-1:0] lane;
    logic [2:0]         bit_pos;
  } find_t;

endpackage

FILE: design/bfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/bfa_find.sv
// First-clear-bit finder over one bitmap row, with per-lane search mask; also gives the row with that bit set.
// Depends on bfa_pkg.
module bfa_find (
  input  logic [bfa_pkg::ROW_BITS-1:0] row_data,
  input  logic [bfa_pkg::LANES-1:0]    lane_ok,
  output bfa_pkg::find_t               find,
  output logic [bfa_pkg::ROW_BITS-1:0] new_row
);

  logic [bfa_pkg::LANES-1:0]     lane_free;
  logic [bfa_pkg::BYTE_BITS-1:0] sel_byte;

  always_comb begin
    for (int i = 0; i < bfa_pkg::LANES; i++) begin
      lane_free[i] = lane_ok[i] &&
                     (row_data[i*bfa_pkg::BYTE_BITS +: bfa_pkg::BYTE_BITS] != 8'hFF);
    end
    find.hit  = |lane_free;
    find.lane = '0;
    for (int i = bfa_pkg::LANES - 1; i >= 0; i--) begin
      if (lane_free[i]) begin
        find.lane = bfa_pkg::LANE_AW'(i);
      end
    end
    sel_byte     = row_data[find.lane*bfa_pkg::BYTE_BITS +: bfa_pkg::BYTE_BITS];
    find.bit_pos = '0;
    for (int b = bfa_pkg::BYTE_BITS - 1; b >= 0; b--) begin
      if (!sel_byte[b]) begin
        find.bit_pos = 3'(b);
      end
    end
    new_row = row_data;
    if (find.hit) begin
      new_row[find.lane*bfa_pkg::BYTE_BITS + 32'(find.bit_pos)] = 1'b1;
    end
  end

endmodule

FILE: design/bitmap_first_free_allocator_top.sv
// Latency: load and read answer 2 cycles after the accepted beat, an unused code or an
// allocate over zero bytes 1 cycle; allocate takes 2 + k, k the 16-byte row of the free bit
// or the last row searched (up to 65 at 1024 bytes). Busy drops as the result shows.
// Throughput: one RAM row per cycle through the shared finder; the receiver cannot stall.
// Reset: a clearing pass writes ceil(BITMAP_BYTES/16) rows (64 by default), busy high.
// Top level of the bitmap allocator; depends on bfa_pkg, bfa_ram, bfa_find, defines header.
`include "bitmap_first_free_allocator_top_defines.svh"
module bitmap_first_free_allocator_top #(
  parameter int BITMAP_BYTES = bfa_pkg::BITMAP_BYTES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bfa_pkg::cmd_t cmd,
  output logic          done,
  output bfa_pkg::rsp_t result,
  input  logic          cfg_wr_en,
  input  logic [10:0]   cfg_wr_data
);

  localparam int ROWS   = (BITMAP_BYTES + bfa_pkg::LANES - 1) / bfa_pkg::LANES;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);
  localparam logic [10:0] SEARCH_MAX =
    11'((BITMAP_BYTES < bfa_pkg::SEARCH_SPAN) ? BITMAP_BYTES : bfa_pkg::SEARCH_SPAN);

  typedef enum logic [1:0] {CLEAR, IDLE, ACCESS, EVAL} state_t;

  state_t                        state;
  logic [ROW_AW-1:0]             row;
  logic [1:0]                    act;
  logic [bfa_pkg::LANE_AW-1:0]   lane;
  logic [7:0]                    data;
  logic                          in_range;
  logic [10:0]                   lim;
  logic [10:0]                   lim_next;
  logic [10:0]                   bytes_in_use;
  logic [ROW_AW-1:0]             row_start;
  logic [ROW_AW-1:0]             rd_addr;
  logic                          wr_en;
  logic [bfa_pkg::ROW_BITS-1:0]  wr_data;
  logic [bfa_pkg::ROW_BITS-1:0]  rd_data;
  logic [bfa_pkg::ROW_BITS-1:0]  new_row;
  logic [bfa_pkg::LANES-1:0]     lane_ok;
  logic [10:0]                   last_byte;
  logic                          last_row;
  logic [7:0]                    read_byte;
  bfa_pkg::find_t                find;

  assign busy      = (state != IDLE);
  assign lim_next  = (bytes_in_use > SEARCH_MAX) ? SEARCH_MAX : bytes_in_use;
  assign row_start = (cmd.action == bfa_pkg::ACT_ALLOC) ? '0
                                                       : ROW_AW'(cmd.byte_addr >> 4);
  assign last_byte = lim - 11'd1;
  assign last_row  = (13'(row) == 13'(last_byte[10:4]));
  assign read_byte = ((act == bfa_pkg::ACT_READ) && in_range)
                     ? rd_data[lane*bfa_pkg::BYTE_BITS +: bfa_pkg::BYTE_BITS] : 8'd0;

  always_comb begin
    for (int i = 0; i < bfa_pkg::LANES; i++) begin
      lane_ok[i] = (13'(row) < 13'(lim[10:4])) ||
                   ((13'(row) == 13'(lim[10:4])) && (5'(i) < 5'(lim[3:0])));
    end
  end

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_data = rd_data;
    case (state)
      CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      IDLE: begin
        rd_addr = row_start;
      end
      ACCESS: begin
        wr_en = (act == bfa_pkg::ACT_LOAD) && in_range;
        wr_data[lane*bfa_pkg::BYTE_BITS +: bfa_pkg::BYTE_BITS] = data;
      end
      EVAL: begin
        rd_addr = row + 1'b1;
        wr_en   = find.hit;
        wr_data = new_row;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  bfa_ram #(
    .WIDTH (bfa_pkg::ROW_BITS),
    .DEPTH (ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (row),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bfa_find u_find (
    .row_data (rd_data),
    .lane_ok  (lane_ok),
    .find     (find),
    .new_row  (new_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= bfa_pkg::BYTES_IN_USE_RESET;
    end else if (cfg_wr_en) begin
      bytes_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
      row   <= '0;
      done  <= 1'b0;
    end else begin
      case (state)
        CLEAR: begin
          done <= 1'b0;
          row  <= (row == ROW_LAST) ? '0 : row + 1'b1;
          if (row == ROW_LAST) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (start) begin
            act      <= cmd.action;
            lane     <= cmd.byte_addr[bfa_pkg::LANE_AW-1:0];
            data     <= cmd.byte_data;
            in_range <= (13'(cmd.byte_addr) < 13'(BITMAP_BYTES));
            lim      <= lim_next;
            row      <= row_start;
            case (cmd.action)
              bfa_pkg::ACT_LOAD, bfa_pkg::ACT_READ: begin
                done  <= 1'b0;
                state <= ACCESS;
              end
              bfa_pkg::ACT_ALLOC: begin
                if (lim_next == '0) begin
                  done   <= 1'b1;
                  result <= '0;
                end else begin
                  done  <= 1'b0;
                  state <= EVAL;
                end
              end
              default: begin
                done   <= 1'b1;
                result <= '0;
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        ACCESS: begin
          done   <= 1'b1;
          result <= {1'b0, 13'd0, read_byte};
          state  <= IDLE;
        end
        EVAL: begin
          if (find.hit) begin
            done   <= 1'b1;
            result <= {1'b1, 13'({row, find.lane, find.bit_pos}), 8'd0};
            state  <= IDLE;
          end else if (last_row) begin
            done   <= 1'b1;
            result <= '0;
            state  <= IDLE;
          end else begin
            done <= 1'b0;
            row  <= row + 1'b1;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= IDLE;
        end
      endcase
    end
  end

  `BFA_ASSERT_ALWAYS(a_clear_after_reset, rst |=> busy && !done, "no clearing pass")
  `BFA_ASSERT_RUN(a_done_has_cause, done |-> $past(busy || start), "result without beat")
  `BFA_ASSERT_RUN(a_found_in_limit, done && result.found |-> (result.bit_index[12:3] < lim), "index past search limit")
  `BFA_ASSERT_RUN(a_miss_zero, done && !result.found |-> (result.bit_index == '0), "miss with index")
  `BFA_ASSERT_RUN(a_write_when_busy, wr_en |-> busy, "RAM write while idle")

endmodule

FILE: dv/bitmap_first_free_allocator_top_test.sv
// Self-checking testbench for bitmap_first_free_allocator_top: load, read and allocate beats
// against a bitmap mirror in a scoreboard class. Depends on bfa_pkg and the allocator RTL.
module bitmap_first_free_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int STORE_BYTES = bfa_pkg::BITMAP_BYTES_DEFAULT;
  localparam int STALL_LIMIT = 2000;

  class bitmap_scoreboard;
    logic [7:0] bitmap [STORE_BYTES];
    logic [10:0] bytes_in_use;
    bfa_pkg::rsp_t rsp_due [$];
    int mismatches;
    int beats;
    int placed;
    int full_reports;
    int reads;
    int settings;

    function new();
      foreach (bitmap[i]) bitmap[i] = 8'h00;
      bytes_in_use = bfa_pkg::BYTES_IN_USE_RESET;
    endfunction

    function void set_bytes_in_use(logic [10:0] v);
      bytes_in_use = v;
      settings++;
    endfunction

    function int pending();
      return rsp_due.size();
    endfunction

    function void note_cmd(bfa_pkg::cmd_t c);
      bfa_pkg::rsp_t e;
      int reach;
      e = '0;
      beats++;
      case (c.action)
        bfa_pkg::ACT_LOAD: begin
          if (c.byte_addr < STORE_BYTES) bitmap[c.byte_addr] = c.byte_data;
        end
        bfa_pkg::ACT_READ: begin
          if (c.byte_addr < STORE_BYTES) e.read_data = bitmap[c.byte_addr];
          reads++;
        end
        bfa_pkg::ACT_ALLOC: begin
          reach = bytes_in_use;
          if (reach > STORE_BYTES) reach = STORE_BYTES;
          if (reach > bfa_pkg::SEARCH_SPAN) reach = bfa_pkg::SEARCH_SPAN;
          for (int i = 0; i < reach && !e.found; i++) begin
            for (int b = 0; b < bfa_pkg::BYTE_BITS && !e.found; b++) begin
              if (!bitmap[i][b]) begin
                bitmap[i][b] = 1'b1;
                e.found = 1'b1;
                e.bit_index = 13'(i * bfa_pkg::BYTE_BITS + b);
              end
            end
          end
          if (e.found) placed++;
          else full_reports++;
        end
        default: ;
      endcase
      rsp_due.push_back(e);
    endfunction

    function void compare_field(string name, logic [12:0] exp_v, logic [12:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_rsp(bfa_pkg::rsp_t r);
      bfa_pkg::rsp_t e;
      if (rsp_due.size() == 0) begin
        $display("%0t: result with nothing due: expected none, actual %h", $time, r);
        mismatches++;
        return;
      end
      e = rsp_due.pop_front();
      compare_field("found", 13'(e.found), 13'(r.found));
      compare_field("bit_index", e.bit_index, r.bit_index);
      compare_field("read_data", 13'(e.read_data), 13'(r.read_data));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bfa_pkg::cmd_t cmd = '0;
  logic done;
  bfa_pkg::rsp_t result;
  logic cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;

  bitmap_scoreboard sb = new();
  bit sender_idles = 1'b1;
  int window = STORE_BYTES;
  int stall_count = 0;

  bitmap_first_free_allocator_top uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en === 1'b1) sb.set_bytes_in_use(cfg_wr_data);
      if (done === 1'b1) sb.check_rsp(result);
      if (start === 1'b1 && busy === 1'b0) sb.note_cmd(cmd);
      if (done === 1'b1 || (start === 1'b1 && busy === 1'b0) || cfg_wr_en === 1'b1) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("%0t: watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("bitmap_first_free_allocator_top_test NOT OK");
        $finish;
      end
    end
  end

  task automatic issue(logic [1:0] act, logic [9:0] addr, logic [7:0] data);
    bfa_pkg::cmd_t c;
    int gap;
    c.action = act;
    c.byte_addr = addr;
    c.byte_data = data;
    if (sender_idles && $urandom_range(0, 99) < 17) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 80) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  task automatic write_bytes_in_use(logic [10:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (v == 0) window = 8;
    else if (v > STORE_BYTES) window = STORE_BYTES;
    else window = v;
  endtask

  task automatic random_item();
    int r;
    int top;
    logic [9:0] a;
    logic [7:0] d;
    top = (window + 2 > 1023) ? 1023 : window + 2;
    if ($urandom_range(0, 4) == 0) a = 10'($urandom_range(0, 1023));
    else a = 10'($urandom_range(0, top));
    r = $urandom_range(0, 9);
    if (r < 5) d = 8'hFF;
    else if (r < 8) d = ~(8'h01 << $urandom_range(0, 7));
    else d = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 45) begin
      issue(bfa_pkg::ACT_ALLOC, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
    end else if (r < 75) begin
      issue(bfa_pkg::ACT_LOAD, a, d);
    end else if (r < 95) begin
      issue(bfa_pkg::ACT_READ, a, 8'($urandom_range(0, 255)));
    end else begin
      issue(ACT_NONE, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [10:0] phase_lim [10];
    phase_lim = '{11'd1, 11'd2, 11'd0, 11'd16, 11'd17, 11'd40, 11'd1023, 11'd2047,
                  11'd1024, 11'd0};
    phase_lim[9] = 11'($urandom_range(1, 2047));
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    issue(bfa_pkg::ACT_READ, 10'd0, 8'h00);
    issue(bfa_pkg::ACT_READ, 10'd1023, 8'hFF);
    issue(bfa_pkg::ACT_ALLOC, 10'd0, 8'h00);
    issue(bfa_pkg::ACT_ALLOC, 10'h3FF, 8'hFF);
    issue(bfa_pkg::ACT_LOAD, 10'd0, 8'hFF);
    issue(bfa_pkg::ACT_LOAD, 10'd1023, 8'hA5);
    issue(bfa_pkg::ACT_READ, 10'd1023, 8'h00);
    issue(bfa_pkg::ACT_LOAD, 10'd1, 8'h7F);
    issue(bfa_pkg::ACT_ALLOC, 10'd0, 8'h00);
    issue(ACT_NONE, 10'd1023, 8'hFF);
    issue(bfa_pkg::ACT_READ, 10'd1, 8'h00);
    issue(bfa_pkg::ACT_LOAD, 10'd1, 8'h00);
    write_bytes_in_use(11'd1);
    issue(bfa_pkg::ACT_ALLOC, 10'd0, 8'h00);
    issue(bfa_pkg::ACT_LOAD, 10'd0, 8'h00);
    write_bytes_in_use(11'd0);
    issue(bfa_pkg::ACT_ALLOC, 10'd0, 8'h00);
    issue(bfa_pkg::ACT_READ, 10'd0, 8'h00);
    write_bytes_in_use(11'd1);
    issue(bfa_pkg::ACT_ALLOC, 10'd0, 8'h00);
    issue(bfa_pkg::ACT_ALLOC, 10'd0, 8'h00);
    write_bytes_in_use(11'd1024);
    issue(bfa_pkg::ACT_LOAD, 10'h2AA, 8'h5A);
    issue(bfa_pkg::ACT_READ, 10'h2AA, 8'h00);

    foreach (phase_lim[p]) begin
      write_bytes_in_use(phase_lim[p]);
      repeat (65) random_item();
    end

    // fill the whole bitmap, then drain the last byte down to a full report
    sender_idles = 1'b0;
    write_bytes_in_use(11'd2047);
    for (int a = 0; a < 1023; a++) begin
      issue(bfa_pkg::ACT_LOAD, 10'(a), 8'hFF);
      if ($urandom_range(0, 31) == 0) issue(bfa_pkg::ACT_ALLOC, 10'(a), 8'h00);
    end
    issue(bfa_pkg::ACT_LOAD, 10'd1023, 8'($urandom_range(0, 254)));
    repeat (9) issue(bfa_pkg::ACT_ALLOC, 10'd0, 8'h00);
    issue(bfa_pkg::ACT_READ, 10'd1023, 8'h00);
    sender_idles = 1'b1;
    write_bytes_in_use(11'd1024);
    issue(bfa_pkg::ACT_ALLOC, 10'd0, 8'h00);
    issue(bfa_pkg::ACT_LOAD, 10'd1023, 8'h00);
    write_bytes_in_use(11'd1023);
    issue(bfa_pkg::ACT_ALLOC, 10'd0, 8'h00);
    write_bytes_in_use(11'd1024);
    issue(bfa_pkg::ACT_ALLOC, 10'd0, 8'h00);

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d beats: %0d bits placed, %0d full reports, %0d reads",
             sb.beats, sb.placed, sb.full_reports, sb.reads);
    $display("search limit rewritten %0d times, including 0, 1, 1023, 1024 and 2047",
             sb.settings);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("bitmap_first_free_allocator_top_test OK");
    end else begin
      $display("bitmap_first_free_allocator_top_test NOT OK");
    end
    $finish;
  end

endmodule
